>>> rtl/core/fat12_fat16_entry_access_macros.svh
// Assertion macros shared by the FAT entry access block.
`ifndef FAT12_FAT16_ENTRY_ACCESS_MACROS_SVH
`define FAT12_FAT16_ENTRY_ACCESS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FATEA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FATEA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fatea_pkg.sv
// Types, codes and constants for the FAT entry access block.
package fatea_pkg;

  localparam int WINDOW_BYTES_DEF = 1024;
  localparam int SECTOR_BYTES_DEF = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_SECTORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLUSTER      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_COPIES       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_FAT  = 2'd3;

  localparam logic [15:0] RESERVED_SECTORS_RST = 16'd1;
  localparam logic [15:0] MAX_CLUSTER_RST      = 16'd4084;
  localparam logic [7:0]  FAT_COPIES_RST       = 8'd2;
  localparam logic [15:0] SECTORS_PER_FAT_RST  = 16'd9;

  // Largest cluster number that still uses 12-bit packing.
  localparam logic [15:0] FAT12_MAX_CLUSTER = 16'hff6;
  localparam logic [31:0] TAG_EMPTY         = 32'hffff_ffff;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_WR
  } state_t;

  // Location of an entry as produced by the address unit.
  typedef struct packed {
    logic [31:0] entry_sector;
    logic [31:0] mirror_sector;
    logic [8:0]  byte_offset;
    logic        odd;
  } loc_t;

  typedef struct packed {
    logic [7:0]  high_byte;
    logic [7:0]  low_byte;
    logic [8:0]  byte_offset;
    logic [31:0] mirror_sector;
    logic [31:0] entry_sector;
    logic        window_miss;
    logic        copies_differ;
    logic [15:0] entry_value;
  } res_t;

endpackage

>>> rtl/core/fatea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fatea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/fatea_addr.sv
// Entry address unit: byte offset, FAT sector, mirror sector and in-sector offset.
module fatea_addr
  import fatea_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic [15:0]                     slot,
  input  logic                            fat16,
  input  logic [15:0]                     reserved_sectors,
  input  logic [15:0]                     sectors_per_fat,
  output loc_t                            loc,
  output logic [$clog2(SECTOR_BYTES)-1:0] sec_off
);

  localparam int SECT_W = $clog2(SECTOR_BYTES);

  logic [17:0] slot_x3;
  logic [16:0] offs;
  logic [31:0] sector;

  always_comb begin
    // FAT12 entries take a byte and a half: 3*slot/2
    slot_x3 = {1'b0, slot, 1'b0} + {2'b00, slot};
    offs    = fat16 ? {slot, 1'b0} : slot_x3[17:1];
    sector  = {16'h0000, reserved_sectors} + 32'(offs >> SECT_W);

    loc.entry_sector  = sector;
    loc.mirror_sector = sector + {16'h0000, sectors_per_fat};
    loc.byte_offset   = offs[8:0];
    loc.odd           = slot[0];
    sec_off           = offs[SECT_W-1:0];
  end

endmodule

>>> rtl/core/fat12_fat16_entry_access.sv
// FAT12/FAT16 entry access through a tagged two-copy sector window.
// Each input transfer is a read, a write or a window fill. Fills, misses and
// unused actions complete straight from idle. A hit read passes through LO and
// HI, a hit write through LO, HI and WR: both window copies sit in byte-wide
// RAMs with one read and one write port and a registered read, so the two
// entry bytes are read in turn and, for a write, written back in turn. Results
// go to an output register; a new input transfer is taken only while that
// register is empty or its result leaves in the same cycle, so a stalled
// result stalls the input. Window bytes never filled read back undefined.
module fat12_fat16_entry_access
  import fatea_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // cfg port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot[15:0], new_entry[31:16], fill_index[41:32], fill_byte[49:42],
  // window_sector[81:50], zero pad
  input  logic [87:0]           in_tdata,
  // action[1:0], fill_copy[2]
  input  logic [2:0]            in_tuser,
  // fill_last
  input  logic                  in_tlast,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // entry_value[15:0], entry_sector[47:16], mirror_sector[79:48],
  // byte_offset[88:80], low_byte[96:89], high_byte[104:97], zero pad
  output logic [111:0]          out_tdata,
  // copies_differ[0], window_miss[1]
  output logic [1:0]            out_tuser
);

  localparam int WIN_W  = $clog2(WINDOW_BYTES);
  localparam int SECT_W = $clog2(SECTOR_BYTES);

  // input fields
  logic [1:0]  in_action;
  logic [15:0] in_slot;
  logic [15:0] in_new_entry;
  logic        in_fill_copy;
  logic [9:0]  in_fill_index;
  logic [7:0]  in_fill_byte;
  logic [31:0] in_window_sector;

  assign in_action        = in_tuser[1:0];
  assign in_fill_copy     = in_tuser[2];
  assign in_slot          = in_tdata[15:0];
  assign in_new_entry     = in_tdata[31:16];
  assign in_fill_index    = in_tdata[41:32];
  assign in_fill_byte     = in_tdata[49:42];
  assign in_window_sector = in_tdata[81:50];

  // configuration
  logic [15:0] reserved_sectors_r;
  logic [15:0] max_cluster_r;
  logic [7:0]  fat_copies_r;
  logic [15:0] sectors_per_fat_r;
  logic        fat16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_sectors_r <= RESERVED_SECTORS_RST;
      max_cluster_r      <= MAX_CLUSTER_RST;
      fat_copies_r       <= FAT_COPIES_RST;
      sectors_per_fat_r  <= SECTORS_PER_FAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESERVED_SECTORS: reserved_sectors_r <= cfg_wdata;
        CFG_MAX_CLUSTER:      max_cluster_r      <= cfg_wdata;
        CFG_FAT_COPIES:       fat_copies_r       <= cfg_wdata[7:0];
        CFG_SECTORS_PER_FAT:  sectors_per_fat_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fat16 = max_cluster_r > FAT12_MAX_CLUSTER;

  // address unit
  loc_t              loc;
  logic [SECT_W-1:0] sec_off;
  logic [WIN_W-1:0]  lo_idx;
  logic              hit;

  fatea_addr #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_addr (
    .slot             (in_slot),
    .fat16            (fat16),
    .reserved_sectors (reserved_sectors_r),
    .sectors_per_fat  (sectors_per_fat_r),
    .loc              (loc),
    .sec_off          (sec_off)
  );

  // state
  state_t           state_r, state_nxt;
  logic [31:0]      window_tag_r;
  logic             is_write_r;
  logic [15:0]      new_entry_r;
  loc_t             loc_r;
  logic [WIN_W-1:0] lo_idx_r;
  logic [WIN_W-1:0] hi_idx_r;
  logic [7:0]       lo1_r;
  logic [7:0]       lo2_r;
  logic [7:0]       new_hi_r;
  logic             out_valid_r;
  res_t             res_r;

  // RAM ports
  logic             first_we, mirror_we;
  logic [WIN_W-1:0] waddr;
  logic [7:0]       wdata;
  logic [WIN_W-1:0] raddr;
  logic [7:0]       first_rdata, mirror_rdata;

  fatea_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (first_rdata)
  );

  fatea_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_mirror_ram (
    .clk   (clk),
    .we    (mirror_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (mirror_rdata)
  );

  logic in_xfer;
  logic out_free;
  logic access;
  logic start_rmw;
  logic load_out;
  res_t res_nxt;

  // merge results
  logic [15:0] v1, v2;
  logic [7:0]  new_lo, new_hi;

  function automatic logic [15:0] unpack(input logic [7:0] lo, input logic [7:0] hi,
                                         input logic is16, input logic odd);
    logic [15:0] v;
    if (is16) begin
      v = {hi, lo};
    end else if (odd) begin
      v = {4'h0, hi, lo[7:4]};
    end else begin
      v = {4'h0, hi[3:0], lo};
    end
    return v;
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign access    = (in_action == ACT_READ) || (in_action == ACT_WRITE);
  assign hit       = loc.entry_sector == window_tag_r;
  assign start_rmw = in_xfer && access && hit;
  assign lo_idx    = WIN_W'(sec_off);

  always_comb begin
    v1 = unpack(lo1_r, first_rdata, fat16, loc_r.odd);
    v2 = (fat_copies_r < 8'd2) ? v1 : unpack(lo2_r, mirror_rdata, fat16, loc_r.odd);
    new_lo = lo1_r;
    new_hi = first_rdata;
    if (fat16) begin
      new_lo = new_entry_r[7:0];
      new_hi = new_entry_r[15:8];
    end else if (!loc_r.odd) begin
      new_lo = new_entry_r[7:0];
      new_hi = {first_rdata[7:4], new_entry_r[11:8]};
    end else begin
      // clear the old nibble before merging
      new_lo = {new_entry_r[3:0], lo1_r[3:0]};
      new_hi = new_entry_r[11:4];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start_rmw) state_nxt = ST_LO;
      ST_LO:   state_nxt = ST_HI;
      ST_HI:   state_nxt = is_write_r ? ST_WR : ST_IDLE;
      ST_WR:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs: RAM controls and result loading
  always_comb begin
    first_we  = 1'b0;
    mirror_we = 1'b0;
    waddr     = WIN_W'(in_fill_index);
    wdata     = in_fill_byte;
    raddr     = hi_idx_r;
    load_out  = 1'b0;
    res_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        raddr = lo_idx;
        if (in_xfer) begin
          if (in_action == ACT_FILL) begin
            first_we  = !in_fill_copy;
            mirror_we = in_fill_copy;
          end
          if (!(access && hit)) begin
            load_out = 1'b1;
            if (access) begin
              res_nxt.window_miss   = 1'b1;
              res_nxt.entry_sector  = loc.entry_sector;
              res_nxt.mirror_sector = loc.mirror_sector;
              res_nxt.byte_offset   = loc.byte_offset;
            end
          end
        end
      end
      ST_LO: ;
      ST_HI: begin
        load_out              = 1'b1;
        res_nxt.entry_value   = v1;
        res_nxt.copies_differ = v1 != v2;
        res_nxt.entry_sector  = loc_r.entry_sector;
        res_nxt.mirror_sector = loc_r.mirror_sector;
        res_nxt.byte_offset   = loc_r.byte_offset;
        if (is_write_r) begin
          res_nxt.low_byte  = new_lo;
          res_nxt.high_byte = new_hi;
          first_we          = 1'b1;
          mirror_we         = 1'b1;
          waddr             = lo_idx_r;
          wdata             = new_lo;
        end
      end
      ST_WR: begin
        first_we  = 1'b1;
        mirror_we = 1'b1;
        waddr     = hi_idx_r;
        wdata     = new_hi_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_tag_r <= TAG_EMPTY;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer && in_action == ACT_FILL && in_tlast) begin
        window_tag_r <= in_window_sector;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_rmw) begin
      is_write_r  <= in_action == ACT_WRITE;
      new_entry_r <= in_new_entry;
      loc_r       <= loc;
      lo_idx_r    <= lo_idx;
      hi_idx_r    <= lo_idx + WIN_W'(1);
    end
    if (state_r == ST_LO) begin
      lo1_r <= first_rdata;
      lo2_r <= mirror_rdata;
    end
    if (state_r == ST_HI) begin
      new_hi_r <= new_hi;
    end
    if (load_out) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.window_miss, res_r.copies_differ};
  assign out_tdata  = {7'b0, res_r.high_byte, res_r.low_byte, res_r.byte_offset,
                       res_r.mirror_sector, res_r.entry_sector, res_r.entry_value};

`include "fat12_fat16_entry_access_macros.svh"

  `FATEA_ASSERT_IMP(a_wr_follows_hi, state_r == ST_WR, $past(state_r == ST_HI) && is_write_r, "write-back of high byte without a preceding write merge")
  `FATEA_ASSERT_IMP(a_no_write_in_lo, state_r == ST_LO, !first_we && !mirror_we, "RAM write while the low bytes are being read")
  `FATEA_ASSERT_NXT(a_result_held, out_valid_r && !out_tready, out_valid_r, "pending result dropped before transfer")
  `FATEA_ASSERT_IMP(a_no_overwrite, load_out, !out_valid_r || out_tready, "result register overwritten while a result is pending")

endmodule

>>> tb/tb_fat12_fat16_entry_access.sv
// Self-checking testbench for the FAT12/FAT16 entry access block: directed table plus random traffic.
module tb_fat12_fat16_entry_access;
  import fatea_pkg::*;

  localparam int WIN_BYTES = WINDOW_BYTES_DEF;
  localparam int SEC_BYTES = SECTOR_BYTES_DEF;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASES = 6;
  localparam int LONG_HOLD = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] slot;
    logic [15:0] new_entry;
    logic        fill_copy;
    logic [9:0]  fill_index;
    logic [7:0]  fill_byte;
    logic        fill_last;
    logic [31:0] window_sector;
  } fat_req_t;

  typedef struct packed {
    fat_req_t req;
    logic     fixed;
    res_t     want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  // slot, new_entry, fill_index, fill_byte, window_sector, zero pad
  logic [87:0] in_tdata;
  // action, fill_copy
  logic [2:0] in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  // entry_value, entry_sector, mirror_sector, byte_offset, low_byte, high_byte, zero pad
  logic [111:0] out_tdata;
  // copies_differ, window_miss
  logic [1:0] out_tuser;

  // Predicted window contents, which bytes were ever loaded, tag and registers.
  logic [7:0]  first_win  [WIN_BYTES];
  logic [7:0]  mirror_win [WIN_BYTES];
  bit          first_set  [WIN_BYTES];
  bit          mirror_set [WIN_BYTES];
  logic [31:0] tag_q;
  logic [15:0] rsv_q;
  logic [15:0] maxc_q;
  logic [15:0] spf_q;
  logic [7:0]  copies_q;

  res_t     fat_results_due[$];
  dir_row_t dir_rows[$];
  int       fail_count;
  int       items_sent;
  int       tx_quiet;
  bit       rx_hold_req;

  always #5 clk = ~clk;

  fat12_fat16_entry_access uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic bit is_fat16();
    return maxc_q > FAT12_MAX_CLUSTER;
  endfunction

  function automatic void locate_entry(input logic [15:0] slot, output logic [31:0] sector,
                                       output logic [8:0] offs);
    logic [31:0] pos;
    pos = is_fat16() ? {15'd0, slot, 1'b0} : ((32'(slot) * 3) >> 1);
    sector = 32'(rsv_q) + pos / SEC_BYTES;
    offs = 9'(pos % SEC_BYTES);
  endfunction

  function automatic logic [15:0] join_entry(logic [7:0] lo, logic [7:0] hi, bit fat16, bit odd);
    if (fat16) return {hi, lo};
    if (odd) return {4'd0, hi, lo[7:4]};
    return {4'd0, hi[3:0], lo};
  endfunction

  // A hit must only touch bytes that were loaded in both copies.
  function automatic bit access_ok(logic [15:0] slot);
    logic [31:0] sector;
    logic [8:0] offs;
    int a;
    int b;
    locate_entry(slot, sector, offs);
    a = int'(offs) % WIN_BYTES;
    b = (int'(offs) + 1) % WIN_BYTES;
    if (sector != tag_q) return 1'b1;
    return first_set[a] && first_set[b] && mirror_set[a] && mirror_set[b];
  endfunction

  // Slots 0 and 65535 always lie in different sectors, so one of them misses.
  function automatic logic [15:0] miss_slot();
    logic [31:0] sector;
    logic [8:0] offs;
    locate_entry(16'd0, sector, offs);
    return (sector == tag_q) ? 16'hffff : 16'h0000;
  endfunction

  function automatic res_t predict_entry_access(fat_req_t rq);
    res_t r;
    logic [31:0] sector;
    logic [8:0] offs;
    int a;
    int b;
    bit f16;
    bit odd;
    logic [15:0] v1;
    logic [15:0] v2;
    logic [7:0] lo;
    logic [7:0] hi;
    r = '0;
    if (rq.action == ACT_FILL) begin
      if (rq.fill_copy) begin
        mirror_win[rq.fill_index] = rq.fill_byte;
        mirror_set[rq.fill_index] = 1'b1;
      end else begin
        first_win[rq.fill_index] = rq.fill_byte;
        first_set[rq.fill_index] = 1'b1;
      end
      if (rq.fill_last) tag_q = rq.window_sector;
      return r;
    end
    if (rq.action == ACT_SPARE) return r;
    f16 = is_fat16();
    odd = rq.slot[0];
    locate_entry(rq.slot, sector, offs);
    r.entry_sector = sector;
    r.mirror_sector = sector + 32'(spf_q);
    r.byte_offset = offs;
    if (sector != tag_q) begin
      r.window_miss = 1'b1;
      return r;
    end
    a = int'(offs) % WIN_BYTES;
    b = (int'(offs) + 1) % WIN_BYTES;
    v1 = join_entry(first_win[a], first_win[b], f16, odd);
    v2 = (copies_q < 8'd2) ? v1 : join_entry(mirror_win[a], mirror_win[b], f16, odd);
    r.entry_value = v1;
    r.copies_differ = (v1 != v2);
    if (rq.action == ACT_WRITE) begin
      lo = first_win[a];
      hi = first_win[b];
      if (f16) begin
        lo = rq.new_entry[7:0];
        hi = rq.new_entry[15:8];
      end else if (!odd) begin
        lo = rq.new_entry[7:0];
        hi = {hi[7:4], rq.new_entry[11:8]};
      end else begin
        hi = rq.new_entry[11:4];
        lo = {rq.new_entry[3:0], lo[3:0]};
      end
      first_win[a] = lo;
      first_win[b] = hi;
      mirror_win[a] = lo;
      mirror_win[b] = hi;
      first_set[a] = 1'b1;
      first_set[b] = 1'b1;
      mirror_set[a] = 1'b1;
      mirror_set[b] = 1'b1;
      r.low_byte = lo;
      r.high_byte = hi;
    end
    return r;
  endfunction

  function automatic fat_req_t mk_req(logic [1:0] act, logic [15:0] slot, logic [15:0] nv,
                                      logic cp, logic [9:0] idx, logic [7:0] byt,
                                      logic last, logic [31:0] sec);
    fat_req_t rq;
    rq.action = act;
    rq.slot = slot;
    rq.new_entry = nv;
    rq.fill_copy = cp;
    rq.fill_index = idx;
    rq.fill_byte = byt;
    rq.fill_last = last;
    rq.window_sector = sec;
    return rq;
  endfunction

  function automatic res_t miss_res(logic [31:0] es, logic [31:0] ms, logic [8:0] bo);
    res_t r;
    r = '0;
    r.window_miss = 1'b1;
    r.entry_sector = es;
    r.mirror_sector = ms;
    r.byte_offset = bo;
    return r;
  endfunction

  function automatic void add_row(fat_req_t rq, logic fixed, res_t want);
    dir_row_t row;
    row.req = rq;
    row.fixed = fixed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic int tx_gap();
    int r;
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      tx_quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(fat_req_t rq, logic fixed = 1'b0, res_t want = '0);
    int gap;
    res_t pred;
    gap = tx_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {6'd0, rq.window_sector, rq.fill_byte, rq.fill_index, rq.new_entry, rq.slot};
    in_tuser = {rq.fill_copy, rq.action};
    in_tlast = rq.fill_last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = predict_entry_access(rq);
    fat_results_due.push_back(fixed ? want : pred);
    if (rq.action != ACT_SPARE) items_sent++;
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (fat_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_RESERVED_SECTORS: rsv_q = val;
      CFG_MAX_CLUSTER: maxc_q = val;
      CFG_FAT_COPIES: copies_q = val[7:0];
      CFG_SECTORS_PER_FAT: spf_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(logic [15:0] rs, logic [15:0] mc, logic [7:0] cp, logic [15:0] spf);
    drain();
    write_reg(CFG_RESERVED_SECTORS, rs);
    write_reg(CFG_MAX_CLUSTER, mc);
    write_reg(CFG_FAT_COPIES, {8'd0, cp});
    write_reg(CFG_SECTORS_PER_FAT, spf);
  endtask

  function automatic logic [15:0] slot_for(int sec_idx, int o);
    int total;
    total = sec_idx * SEC_BYTES + o;
    return is_fat16() ? 16'(total >> 1) : 16'((total * 2) / 3);
  endfunction

  // Fill a byte run in both copies, commit its tag unless broken, then access entries in the run.
  task automatic fill_and_access();
    int span;
    int sec_idx;
    int start;
    int len;
    int o;
    int tries;
    int i;
    logic [31:0] sec;
    logic [15:0] slot;
    logic [7:0] b;
    logic last;
    bit broken;
    span = is_fat16() ? 256 : 192;
    if ($urandom_range(0, 9) == 0) sec_idx = $urandom_range(0, 1) ? span - 1 : 0;
    else sec_idx = $urandom_range(0, span - 1);
    sec = 32'(rsv_q) + 32'(sec_idx);
    start = $urandom_range(0, SEC_BYTES - 1);
    len = $urandom_range(2, 20);
    if (start + len > SEC_BYTES + 1) len = SEC_BYTES + 1 - start;
    broken = ($urandom_range(0, 9) == 0);
    for (i = 0; i < len; i++) begin
      send_item(mk_req(ACT_FILL, 16'($urandom), 16'($urandom), 1'b0, 10'(start + i),
                       8'($urandom), 1'b0, sec));
    end
    for (i = 0; i < len; i++) begin
      b = ($urandom_range(0, 7) != 0) ? first_win[start + i] : 8'($urandom);
      last = (i == len - 1) && !(broken && $urandom_range(0, 1));
      send_item(mk_req(ACT_FILL, 16'($urandom), 16'($urandom), 1'b1, 10'(start + i), b, last,
                       (broken && last) ? $urandom : sec));
    end
    repeat ($urandom_range(3, 10)) begin
      tries = 0;
      do begin
        o = $urandom_range(start, start + len - 2);
        slot = slot_for(sec_idx, o) + 16'($urandom_range(0, 1));
        tries++;
      end while (!access_ok(slot) && tries < 6);
      if (!access_ok(slot)) slot = miss_slot();
      send_item(mk_req($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, slot, 16'($urandom),
                       1'($urandom), 10'($urandom), 8'($urandom), 1'($urandom), $urandom));
    end
  endtask

  task automatic noise_item();
    fat_req_t rq;
    rq = mk_req(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 10'($urandom),
                8'($urandom), $urandom_range(0, 7) == 0,
                $urandom_range(0, 1) ? $urandom : 32'(rsv_q) + $urandom_range(0, 3));
    if ((rq.action == ACT_READ || rq.action == ACT_WRITE) && !access_ok(rq.slot))
      rq.slot = miss_slot();
    send_item(rq);
  endtask

  task automatic run_random(int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 24) == 0) drain();
      if ($urandom_range(0, 99) < 70) fill_and_access();
      else noise_item();
    end
  endtask

  function automatic void build_table();
    add_row(mk_req(ACT_READ, 16'h0000, 16'h0000, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0),
            1'b1, miss_res(32'd1, 32'd10, 9'd0));
    add_row(mk_req(ACT_WRITE, 16'hffff, 16'hffff, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0),
            1'b1, miss_res(32'd192, 32'd201, 9'd510));
    add_row(mk_req(ACT_SPARE, 16'hffff, 16'hffff, 1'b1, 10'd1023, 8'hff, 1'b1, 32'hffff_ffff),
            1'b1, '0);
    // Committing the empty tag keeps the window empty.
    add_row(mk_req(ACT_FILL, 16'h0000, 16'h0000, 1'b0, 10'd1023, 8'hff, 1'b1, TAG_EMPTY),
            1'b1, '0);
    add_row(mk_req(ACT_READ, 16'h0001, 16'h0000, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0),
            1'b1, miss_res(32'd1, 32'd10, 9'd1));
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b0, 10'd0, 8'h12, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b0, 10'd1, 8'h34, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b0, 10'd2, 8'h56, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b0, 10'd3, 8'h78, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b0, 10'd4, 8'h9a, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b1, 10'd0, 8'h12, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b1, 10'd1, 8'h34, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b1, 10'd2, 8'h56, 1'b0, 32'd1), 1'b1, '0);
    // Mirror byte 3 differs, so slot 2 reads back as a copy mismatch.
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b1, 10'd3, 8'h00, 1'b0, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_FILL, 16'd0, 16'd0, 1'b1, 10'd4, 8'h9a, 1'b1, 32'd1), 1'b1, '0);
    add_row(mk_req(ACT_READ, 16'd0, 16'd0, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk_req(ACT_READ, 16'd1, 16'd0, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk_req(ACT_READ, 16'd2, 16'd0, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
    // Odd and even FAT12 writes share byte 1: each must keep the other's nibble.
    add_row(mk_req(ACT_WRITE, 16'd1, 16'h0abc, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk_req(ACT_WRITE, 16'd0, 16'h0fff, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk_req(ACT_WRITE, 16'd2, 16'hf000, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk_req(ACT_READ, 16'd1, 16'd0, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
    add_row(mk_req(ACT_READ, 16'd2, 16'd0, 1'b0, 10'd0, 8'h00, 1'b0, 32'd0), 1'b0, '0);
  endfunction

  task automatic cmp(string fld, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fld, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (fat_results_due.size() == 0) begin
      $error("result transfer with no expected entry");
      fail_count++;
    end else begin
      want = fat_results_due.pop_front();
      cmp("entry_value", 32'(want.entry_value), 32'(out_tdata[15:0]));
      cmp("copies_differ", 32'(want.copies_differ), 32'(out_tuser[0]));
      cmp("window_miss", 32'(want.window_miss), 32'(out_tuser[1]));
      cmp("entry_sector", want.entry_sector, out_tdata[47:16]);
      cmp("mirror_sector", want.mirror_sector, out_tdata[79:48]);
      cmp("byte_offset", 32'(want.byte_offset), 32'(out_tdata[88:80]));
      cmp("low_byte", 32'(want.low_byte), 32'(out_tdata[96:89]));
      cmp("high_byte", 32'(want.high_byte), 32'(out_tdata[104:97]));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  initial begin : rx_side
    int wait_left;
    int quiet_left;
    int r;
    wait_left = 0;
    quiet_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (wait_left > 0) begin
        out_tready = 1'b0;
        wait_left--;
      end else if (quiet_left > 0) begin
        out_tready = 1'b1;
        quiet_left--;
      end else begin
        out_tready = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 5) quiet_left = $urandom_range(20, 60);
        else if (r < 25) wait_left = $urandom_range(1, 3);
        else if (r < 28) wait_left = $urandom_range(10, 25);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL fat12_fat16_entry_access");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    fail_count = 0;
    items_sent = 0;
    tx_quiet = 0;
    rx_hold_req = 1'b0;
    tag_q = TAG_EMPTY;
    rsv_q = RESERVED_SECTORS_RST;
    maxc_q = MAX_CLUSTER_RST;
    copies_q = FAT_COPIES_RST;
    spf_q = SECTORS_PER_FAT_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    build_table();
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
    run_random(RANDOM_ITEMS / PHASES);

    apply_cfg(16'd0, FAT12_MAX_CLUSTER + 16'd1, 8'd1, 16'hffff);
    rx_hold_req = 1'b1;
    run_random(RANDOM_ITEMS / PHASES);

    apply_cfg(16'hffff, 16'hffff, 8'd255, 16'd1);
    run_random(RANDOM_ITEMS / PHASES);

    apply_cfg(16'($urandom), FAT12_MAX_CLUSTER, 8'd2, 16'($urandom_range(1, 65535)));
    rx_hold_req = 1'b1;
    run_random(RANDOM_ITEMS / PHASES);

    apply_cfg(16'($urandom), 16'd0, 8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)));
    run_random(RANDOM_ITEMS / PHASES);

    apply_cfg(16'($urandom_range(0, 64)), 16'($urandom_range(16'hff7, 16'hffff)), 8'd2,
              16'($urandom_range(1, 65535)));
    run_random(RANDOM_ITEMS / PHASES);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS fat12_fat16_entry_access");
    else $display("FAIL fat12_fat16_entry_access");
    $finish;
  end

endmodule
